// ===== src/ufs_pkg.sv =====
// ----------------------------------------------------------------------------
// ufs_pkg
// shared widths and register map of the disjoint-set table
// ----------------------------------------------------------------------------
package ufs_pkg;
	localparam int ROOT_W  = 10;
	localparam int SIZE_W  = 11;
	localparam int RANK_W  = 4;
	localparam int COUNT_W = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [RANK_W-1:0]  RANK_MAX  = 4'd15;
	localparam logic [RANK_W-1:0]  RANK_INIT = 4'd1;
	localparam logic [SIZE_W-1:0]  SIZE_INIT = 11'd1;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic [PADDR_W-1:0] ADDR_ACTIVE_COUNT = 3'd0;
endpackage

// ===== src/ufs_req_if.sv =====
// ----------------------------------------------------------------------------
// ufs_req_if
// request channel: two element indices
// ----------------------------------------------------------------------------
interface ufs_req_if import ufs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ROOT_W-1:0] first_index;
	logic [ROOT_W-1:0] second_index;

	modport source (output valid, first_index, second_index, input ready);
	modport sink   (input valid, first_index, second_index, output ready);
endinterface

// ===== src/ufs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ufs_rsp_if
// result channel: roots, set sizes and flags
// ----------------------------------------------------------------------------
interface ufs_rsp_if import ufs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ROOT_W-1:0] first_root;
	logic [ROOT_W-1:0] second_root;
	logic [SIZE_W-1:0] first_set_size;
	logic [SIZE_W-1:0] second_set_size;
	logic              merged;
	logic              range_error;

	modport source (output valid, first_root, second_root, first_set_size,
		second_set_size, merged, range_error, input ready);
	modport sink   (input valid, first_root, second_root, first_set_size,
		second_set_size, merged, range_error, output ready);
endinterface

// ===== src/ufs_ram.sv =====
// ----------------------------------------------------------------------------
// ufs_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ufs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/union_find_with_sizes.sv =====
// ----------------------------------------------------------------------------
// union_find_with_sizes
// disjoint-set table with union by rank, path compression and set sizes
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// req      in   valid/ready    first_index, second_index
// rsp      out  valid/ready    first_root, second_root, sizes, merged, range_error
// apb      in   psel/penable   active_count at byte address 0
//
// one request at a time; the time per request grows with da + db, where da and
// db are the path depths of the two elements, set by the single read port of
// the parent memory (one step of a root walk or compression per cycle)
// after reset a clearing pass over all MAX_ELEMENTS entries initializes the memories;
// req.ready stays low meanwhile, apb writes are taken as ever
// the result register frees the input side: a new request is taken while a
// result waits; the next result holds in the merge step until rsp drains
// ----------------------------------------------------------------------------
module union_find_with_sizes import ufs_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	ufs_req_if.sink            req,
	ufs_rsp_if.source          rsp
);
	localparam int IDX_W = $clog2(MAX_ELEMENTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMENTS - 1);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_FIND  = 9'b000000100,
		S_COMP  = 9'b000001000,
		S_NEXT  = 9'b000010000,
		S_SZA   = 9'b000100000,
		S_SZB   = 9'b001000000,
		S_SZC   = 9'b010000000,
		S_MERGE = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration register
	logic [COUNT_W-1:0] active_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ACTIVE_COUNT);
	assign prdata = (paddr == ADDR_ACTIVE_COUNT) ? PDATA_W'(active_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= COUNT_RESET;
		end else if (cfg_wr) begin
			active_q <= pwdata[COUNT_W-1:0];
		end
	end

	// memory ports
	logic             p_we, s_we, k_we;
	logic [IDX_W-1:0] p_waddr, p_wdata, p_raddr, p_rd;
	logic [IDX_W-1:0] s_waddr, k_waddr, sk_raddr;
	logic [SIZE_W-1:0] s_wdata, s_rd;
	logic [RANK_W-1:0] k_wdata, k_rd;

	ufs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_parent (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rd)
	);
	ufs_ram #(.WIDTH(SIZE_W), .DEPTH(MAX_ELEMENTS)) u_size (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(sk_raddr), .rdata(s_rd)
	);
	ufs_ram #(.WIDTH(RANK_W), .DEPTH(MAX_ELEMENTS)) u_rank (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(sk_raddr), .rdata(k_rd)
	);

	// walk and merge registers
	logic [IDX_W-1:0]  clr_q, node_q, start_q, root_q, ra_q, rb_q, b_q;
	logic              phase_q, err_q;
	logic [SIZE_W-1:0] sza_q, szb_q;
	logic [RANK_W-1:0] rka_q, rkb_q;

	// request decode
	logic             req_fire, req_err;
	logic [IDX_W-1:0] a_idx, b_idx;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign a_idx     = IDX_W'(req.first_index);
	assign b_idx     = IDX_W'(req.second_index);
	// limit is active_count capped at MAX_ELEMENTS
	assign req_err = (req.first_index >= active_q) || (req.second_index >= active_q)
		|| (32'(req.first_index) >= MAX_ELEMENTS) || (32'(req.second_index) >= MAX_ELEMENTS);

	// walk decisions on the parent read data
	logic at_root, comp_done;
	assign at_root   = (p_rd == node_q);
	assign comp_done = (p_rd == root_q);

	// merge decisions
	logic              out_free, do_merge, rank_eq, b_big;
	logic [IDX_W-1:0]  big, small_root;
	logic [SIZE_W-1:0] size_sum;

	assign out_free   = !rsp.valid || rsp.ready;
	assign do_merge   = !err_q && (ra_q != rb_q);
	assign rank_eq    = (rka_q == rkb_q);
	assign b_big      = !rank_eq && (rkb_q > rka_q);
	assign big        = b_big ? rb_q : ra_q;
	assign small_root = b_big ? ra_q : rb_q;
	assign size_sum   = sza_q + szb_q;

	always_comb begin
		p_we     = 1'b0;
		p_waddr  = node_q;
		p_wdata  = root_q;
		p_raddr  = node_q;
		s_we     = 1'b0;
		s_waddr  = big;
		s_wdata  = size_sum;
		k_we     = 1'b0;
		k_waddr  = ra_q;
		k_wdata  = (rka_q == RANK_MAX) ? rka_q : rka_q + RANK_W'(1);
		sk_raddr = ra_q;
		unique case (state_q)
			S_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = clr_q;
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = SIZE_INIT;
				k_we    = 1'b1;
				k_waddr = clr_q;
				k_wdata = RANK_INIT;
			end
			S_IDLE: begin
				p_raddr = a_idx;
			end
			S_FIND: begin
				// follow the parent, or start compression at the start node
				p_raddr = at_root ? start_q : p_rd;
			end
			S_COMP: begin
				// point the node straight at the root, move to its old parent
				p_we    = 1'b1;
				p_raddr = p_rd;
			end
			S_NEXT: begin
				p_raddr = b_q;
			end
			S_SZA: begin
				sk_raddr = ra_q;
			end
			S_SZB: begin
				sk_raddr = rb_q;
			end
			S_SZC: begin
				sk_raddr = rb_q;
			end
			S_MERGE: begin
				if (out_free && do_merge) begin
					p_we    = 1'b1;
					p_waddr = small_root;
					p_wdata = big;
					s_we    = 1'b1;
					k_we    = rank_eq;
				end
			end
			default: begin
				p_raddr = node_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			phase_q <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						err_q   <= req_err;
						phase_q <= 1'b0;
						state_q <= req_err ? S_MERGE : S_FIND;
					end
				end
				S_FIND: begin
					if (at_root) begin
						if (start_q != node_q) begin
							state_q <= S_COMP;
						end else if (!phase_q) begin
							state_q <= S_NEXT;
						end else begin
							state_q <= S_SZA;
						end
					end
				end
				S_COMP: begin
					if (comp_done) begin
						state_q <= phase_q ? S_SZA : S_NEXT;
					end
				end
				S_NEXT: begin
					phase_q <= 1'b1;
					state_q <= S_FIND;
				end
				S_SZA: state_q <= S_SZB;
				S_SZB: state_q <= S_SZC;
				S_SZC: state_q <= S_MERGE;
				S_MERGE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers of the walk
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				node_q  <= a_idx;
				start_q <= a_idx;
				b_q     <= b_idx;
			end
			S_FIND: begin
				if (at_root) begin
					root_q <= node_q;
					if (phase_q) begin
						rb_q <= node_q;
					end else begin
						ra_q <= node_q;
					end
					node_q <= start_q;
				end else begin
					node_q <= p_rd;
				end
			end
			S_COMP: begin
				node_q <= p_rd;
			end
			S_NEXT: begin
				node_q  <= b_q;
				start_q <= b_q;
			end
			S_SZB: begin
				sza_q <= s_rd;
				rka_q <= k_rd;
			end
			S_SZC: begin
				szb_q <= s_rd;
				rkb_q <= k_rd;
			end
			default: begin
				node_q <= node_q;
			end
		endcase
	end

	// result register
	logic rsp_valid_q;
	assign rsp.valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_MERGE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MERGE && out_free) begin
			rsp.first_root      <= err_q ? '0 : ROOT_W'(ra_q);
			rsp.second_root     <= err_q ? '0 : ROOT_W'(rb_q);
			rsp.first_set_size  <= err_q ? '0 : sza_q;
			rsp.second_set_size <= err_q ? '0 : szb_q;
			rsp.merged          <= do_merge;
			rsp.range_error     <= err_q;
		end
	end
endmodule

// ===== dv/union_find_with_sizes_checker.sv =====
// ----------------------------------------------------------------------------
// union_find_with_sizes_checker
// predicts each result of the disjoint-set table and compares it on arrival
// ----------------------------------------------------------------------------
module union_find_with_sizes_checker import ufs_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	ufs_req_if                 req,
	ufs_rsp_if                 rsp,
	output int                 outstanding,
	output int                 failures
);
	typedef struct packed {
		logic [ROOT_W-1:0] first_root;
		logic [ROOT_W-1:0] second_root;
		logic [SIZE_W-1:0] first_set_size;
		logic [SIZE_W-1:0] second_set_size;
		logic              merged;
		logic              range_error;
	} set_answer_t;

	logic [ROOT_W-1:0]  parent_of [MAX_ELEMENTS];
	logic [RANK_W-1:0]  rank_of   [MAX_ELEMENTS];
	logic [SIZE_W-1:0]  size_of   [MAX_ELEMENTS];
	logic [COUNT_W-1:0] active_count;
	set_answer_t        pending_answers [$];

	// root walk, then point every node on the path straight at the root
	function automatic logic [ROOT_W-1:0] find_and_compress(logic [ROOT_W-1:0] start);
		logic [ROOT_W-1:0] node;
		logic [ROOT_W-1:0] root;
		logic [ROOT_W-1:0] next;
		int                steps;
		node  = start;
		steps = 0;
		while (parent_of[node] != node && steps < MAX_ELEMENTS) begin
			node = parent_of[node];
			steps++;
		end
		root  = node;
		node  = start;
		steps = 0;
		while (node != root && steps < MAX_ELEMENTS) begin
			next            = parent_of[node];
			parent_of[node] = root;
			node            = next;
			steps++;
		end
		return root;
	endfunction

	function automatic set_answer_t unite_sets(logic [ROOT_W-1:0] a, logic [ROOT_W-1:0] b);
		set_answer_t       ans;
		int unsigned       limit;
		logic [ROOT_W-1:0] ra;
		logic [ROOT_W-1:0] rb;
		logic [ROOT_W-1:0] big;
		logic [ROOT_W-1:0] absorbed;
		ans   = '0;
		limit = (active_count > MAX_ELEMENTS) ? MAX_ELEMENTS : active_count;
		if (a >= limit || b >= limit) begin
			ans.range_error = 1'b1;
			return ans;
		end
		ra = find_and_compress(a);
		rb = find_and_compress(b);
		ans.first_root      = ra;
		ans.second_root     = rb;
		ans.first_set_size  = size_of[ra];
		ans.second_set_size = size_of[rb];
		if (ra != rb) begin
			big      = ra;
			absorbed = rb;
			if (rank_of[ra] == rank_of[rb]) begin
				if (rank_of[ra] < RANK_MAX)
					rank_of[ra] = rank_of[ra] + 1'b1;
			end else if (rank_of[rb] > rank_of[ra]) begin
				big      = rb;
				absorbed = ra;
			end
			parent_of[absorbed] = big;
			size_of[big]        = size_of[big] + size_of[absorbed];
			ans.merged          = 1'b1;
		end
		return ans;
	endfunction

	assign outstanding = pending_answers.size();

	always @(posedge clk or negedge arst_n) begin
		set_answer_t want;
		if (!arst_n) begin
			for (int k = 0; k < MAX_ELEMENTS; k++) begin
				parent_of[k] = k[ROOT_W-1:0];
				rank_of[k]   = RANK_INIT;
				size_of[k]   = SIZE_INIT;
			end
			active_count = COUNT_RESET;
			pending_answers.delete();
			failures = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_ACTIVE_COUNT)
				active_count = pwdata[COUNT_W-1:0];
			if (req.valid && req.ready)
				pending_answers = {pending_answers,
					unite_sets(req.first_index, req.second_index)};
			if (rsp.valid && rsp.ready) begin
				if (pending_answers.size() == 0) begin
					$error("result with no request waiting");
					failures++;
				end else begin
					want = pending_answers.pop_front();
					if (rsp.first_root !== want.first_root) begin
						$error("first_root exp %0d got %0d", want.first_root, rsp.first_root);
						failures++;
					end
					if (rsp.second_root !== want.second_root) begin
						$error("second_root exp %0d got %0d", want.second_root,
							rsp.second_root);
						failures++;
					end
					if (rsp.first_set_size !== want.first_set_size) begin
						$error("first_set_size exp %0d got %0d", want.first_set_size,
							rsp.first_set_size);
						failures++;
					end
					if (rsp.second_set_size !== want.second_set_size) begin
						$error("second_set_size exp %0d got %0d", want.second_set_size,
							rsp.second_set_size);
						failures++;
					end
					if (rsp.merged !== want.merged) begin
						$error("merged exp %0d got %0d", want.merged, rsp.merged);
						failures++;
					end
					if (rsp.range_error !== want.range_error) begin
						$error("range_error exp %0d got %0d", want.range_error,
							rsp.range_error);
						failures++;
					end
				end
			end
		end
	end
endmodule

// ===== dv/union_find_with_sizes_tb.sv =====
// ----------------------------------------------------------------------------
// union_find_with_sizes_tb
// drives requests and active_count writes into the disjoint-set table, with
// random idling on both channels; the checker predicts and compares results
// ----------------------------------------------------------------------------
module union_find_with_sizes_tb;
	import ufs_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	int                 outstanding;
	int                 failures;
	bit                 quiet;     // no idling on either side
	bit                 gaps_on;   // sender idles in bursts

	ufs_req_if req ();
	ufs_rsp_if rsp ();

	union_find_with_sizes i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req),
		.rsp     (rsp)
	);

	union_find_with_sizes_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.req         (req),
		.rsp         (rsp),
		.outstanding (outstanding),
		.failures    (failures)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// hard stop well past the slowest legal run
	initial begin
		#60_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// result side backpressure: random ready bursts, none once quiet
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet || $urandom_range(0, 3) != 0) begin
				rsp.ready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(negedge clk);
			end else begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
		end
	end

	// one request; valid stays high if the next request follows at once
	task automatic send_request(input logic [ROOT_W-1:0] a, input logic [ROOT_W-1:0] b);
		req.valid        <= 1'b1;
		req.first_index  <= a;
		req.second_index <= b;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
	endtask

	// drain every pending result, let the block settle, then write the register
	task automatic set_active_count(input int unsigned count);
		req.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= ADDR_ACTIVE_COUNT;
		pwdata  <= count;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// mostly in-range pairs, some pure queries, some out-of-range noise
	task automatic random_phase(input int unsigned count, input int n_items);
		int unsigned       pick;
		logic [ROOT_W-1:0] a;
		logic [ROOT_W-1:0] b;
		set_active_count(count);
		@(negedge clk);
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 9);
			a    = $urandom_range(0, count - 1);
			b    = $urandom_range(0, count - 1);
			if (pick == 0)
				b = a;
			else if (pick == 1)
				a = $urandom_range(0, 1023);
			else if (pick == 2)
				b = $urandom_range(0, 1023);
			send_request(a, b);
		end
	endtask

	initial begin
		int unsigned plan [6] = '{1024, 8, 64, 0, 2, 1024};
		arst_n    = 1'b0;
		quiet     = 1'b0;
		gaps_on   = 1'b1;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req.valid = 1'b0;
		req.first_index  = '0;
		req.second_index = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: plain queries at the ends, merges on equal and unequal ranks
		send_request(10'd0, 10'd0);
		send_request(10'd1023, 10'd1023);
		send_request(10'd0, 10'd1023);
		send_request(10'd1, 10'd2);
		send_request(10'd1, 10'd2);
		send_request(10'd3, 10'd1);
		send_request(10'd2, 10'd3);
		send_request(10'd4, 10'd5);
		send_request(10'd6, 10'd7);
		send_request(10'd5, 10'd7);
		send_request(10'd1, 10'd7);
		send_request(10'd7, 10'd7);
		send_request(10'd900, 10'd20);
		send_request(10'd682, 10'd341);

		// count change keeps links to roots now out of range
		set_active_count(100);
		@(negedge clk);
		send_request(10'd20, 10'd20);
		send_request(10'd20, 10'd99);
		send_request(10'd99, 10'd100);
		send_request(10'd1023, 10'd0);

		// smallest count: only element zero is usable
		set_active_count(1);
		@(negedge clk);
		send_request(10'd0, 10'd0);
		send_request(10'd0, 10'd1);
		send_request(10'd1, 10'd0);

		// random phases; second has no sender gaps, last no idling at all
		foreach (plan[p]) begin
			gaps_on = (p != 1);
			if (p == 5)
				quiet = 1'b1;
			random_phase(plan[p] == 0 ? $urandom_range(1, 1024) : plan[p], 300);
		end

		req.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/ufs_pkg.sv
src/ufs_req_if.sv
src/ufs_rsp_if.sv
src/ufs_ram.sv
src/union_find_with_sizes.sv
dv/union_find_with_sizes_checker.sv
dv/union_find_with_sizes_tb.sv
